// ===== hdl/u8sd_pkg.sv =====
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared widths, masks and lead-byte decoding for the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
package u8sd_pkg;

   localparam int ByteWidth = 8;
   localparam int CpWidth   = 31;
   localparam int LenWidth  = 3;
   localparam int SixWidth  = 6;

   typedef logic [ByteWidth-1:0] byte_type;
   typedef logic [CpWidth-1:0]   cp_type;
   typedef logic [LenWidth-1:0]  len_type;

   // Sequence lengths
   localparam len_type LenOne   = 3'd1;
   localparam len_type LenTwo   = 3'd2;
   localparam len_type LenThree = 3'd3;
   localparam len_type LenFour  = 3'd4;
   localparam len_type LenFive  = 3'd5;
   localparam len_type LenSix   = 3'd6;

   typedef struct packed {
      len_type  length;   // 1 means the byte stands alone
      byte_type payload;  // bits kept under the prefix
   } lead_type;

   // Classify a lead byte: longest prefix first
   function automatic lead_type lead_decode(byte_type b);
      lead_type r;
      if ((b & 8'hFE) == 8'hFC) begin
         r.length  = LenSix;
         r.payload = b & 8'h01;
      end else if ((b & 8'hFC) == 8'hF8) begin
         r.length  = LenFive;
         r.payload = b & 8'h03;
      end else if ((b & 8'hF8) == 8'hF0) begin
         r.length  = LenFour;
         r.payload = b & 8'h07;
      end else if ((b & 8'hF0) == 8'hE0) begin
         r.length  = LenThree;
         r.payload = b & 8'h0F;
      end else if ((b & 8'hE0) == 8'hC0) begin
         r.length  = LenTwo;
         r.payload = b & 8'h1F;
      end else begin
         r.length  = LenOne;
         r.payload = b;
      end
      return r;
   endfunction

endpackage

// ===== hdl/utf8_stream_decoder.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Decodes a byte stream into code points (six-byte prefix scheme).
//
// Usage:
//   req_valid/req_stall/req_in_byte carry one raw byte per word. A word is
//   taken at a rising edge with req_valid high and req_stall low.
//   rsp_valid/rsp_stall/rsp_code_point/rsp_seq_length carry one decoded code
//   point per word, issued on the byte that closes a sequence (or on a byte
//   that stands alone). Other bytes give no result word.
//   Throughput: one byte per cycle while no waiting result stalls it. A byte
//   is held in the input register, then decoded by the shift/mask/OR path
//   into the result register, from which the result word is offered until
//   the receiver takes it with rsp_stall low.
//   The single decode stage between these two registers sets the rate.
//   While rsp_stall holds a waiting result, the byte that would produce the
//   next result waits in the input register and req_stall rises; bytes that
//   only extend an open sequence still move on.
//   Reset (synchronous, active high) closes any open sequence and empties
//   both registers.
// ----------------------------------------------------------------------------
module utf8_stream_decoder (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  u8sd_pkg::byte_type req_in_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output u8sd_pkg::cp_type  rsp_code_point,
   output u8sd_pkg::len_type rsp_seq_length
);
   import u8sd_pkg::*;

   // Input register
   logic     in_valid_ff, in_valid_in;
   byte_type in_byte_ff,  in_byte_in;

   // Decoder state
   cp_type   acc_ff,   acc_in;
   len_type  left_ff,  left_in;
   len_type  total_ff, total_in;

   // Result register
   logic     rsp_valid_ff, rsp_valid_in;
   cp_type   rsp_cp_ff,    rsp_cp_in;
   len_type  rsp_len_ff,   rsp_len_in;

   lead_type lead;
   cp_type   acc_shift;
   logic     emit;
   logic     advance;
   logic     out_free;

   // Decode the held byte
   always_comb begin
      lead      = lead_decode(in_byte_ff);
      acc_shift = {acc_ff[CpWidth-SixWidth-1:0], in_byte_ff[SixWidth-1:0]};
      if (left_ff == '0) begin
         emit = (lead.length == LenOne);
      end else begin
         emit = (left_ff == LenOne);
      end
   end

   // Move the byte on unless its result cannot be stored
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && (!emit || out_free);
   assign req_stall = in_valid_ff && !advance;

   // Next state
   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      acc_in       = acc_ff;
      left_in      = left_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_cp_in    = rsp_cp_ff;
      rsp_len_in   = rsp_len_ff;

      if (advance) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_in_byte;
      end

      if (advance) begin
         if (left_ff == '0) begin
            if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_cp_in    = {{(CpWidth-ByteWidth){1'b0}}, lead.payload};
               rsp_len_in   = LenOne;
            end else begin
               acc_in   = {{(CpWidth-ByteWidth){1'b0}}, lead.payload};
               total_in = lead.length;
               left_in  = lead.length - LenOne;
            end
         end else begin
            left_in = left_ff - LenOne;
            if (emit) begin
               rsp_valid_in = 1'b1;
               rsp_cp_in    = acc_shift;
               rsp_len_in   = total_ff;
               acc_in       = '0;
               total_in     = '0;
            end else begin
               acc_in = acc_shift;
            end
         end
      end
   end

   // Hold state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         acc_ff       <= '0;
         left_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         acc_ff       <= acc_in;
         left_ff      <= left_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      in_byte_ff <= in_byte_in;
      rsp_cp_ff  <= rsp_cp_in;
      rsp_len_ff <= rsp_len_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_code_point = rsp_cp_ff;
   assign rsp_seq_length = rsp_len_ff;

   // Checks on the decoder state and results
   a_left_range : assert property (@(posedge clock) disable iff (reset)
      left_ff <= LenFive)
      else $error("bytes left out of range");

   a_total_open : assert property (@(posedge clock) disable iff (reset)
      left_ff != '0 |-> (total_ff > left_ff && total_ff <= LenSix))
      else $error("open sequence without a consistent length");

   a_len_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_len_ff >= LenOne && rsp_len_ff <= LenSix))
      else $error("result length out of range");

   a_single_narrow : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_len_ff == LenOne |-> rsp_cp_ff[CpWidth-1:ByteWidth] == '0)
      else $error("single byte result wider than a byte");

endmodule
